/* src/ntoa_pkg.sv */
// ----------------------------------------------------------------------------
// ntoa_pkg
// Shared types, constants and the control program of the number-to-ASCII
// formatter.
// ----------------------------------------------------------------------------
package ntoa_pkg;

   localparam int ValueWidth = 32;
   localparam int BcdDigits  = 10;
   localparam int StepWidth  = 4;

   localparam logic [7:0] CharZero   = 8'h30;
   localparam logic [7:0] CharX      = 8'h78;
   localparam logic [7:0] CharHexOff = 8'h37;
   localparam logic [3:0] NibMask    = 4'hF;

   typedef enum logic [2:0] {
      CMD_DEC2     = 3'd0,
      CMD_DEC3     = 3'd1,
      CMD_DEC5     = 3'd2,
      CMD_DEC10    = 3'd3,
      CMD_HEX2_RAW = 3'd4,
      CMD_HEX2     = 3'd5,
      CMD_HEX4     = 3'd6,
      CMD_HEX8     = 3'd7
   } cmd_type;

   typedef enum logic [2:0] {
      OP_NONE   = 3'd0,
      OP_LOAD   = 3'd1,
      OP_DABBLE = 3'd2,
      OP_EMIT_0 = 3'd3,
      OP_EMIT_X = 3'd4,
      OP_EMIT_D = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      COND_NEVER     = 3'd0,
      COND_ALWAYS    = 3'd1,
      COND_NO_REQ    = 3'd2,
      COND_IS_HEX    = 3'd3,
      COND_NO_PREFIX = 3'd4,
      COND_ITER_NZ   = 3'd5,
      COND_CHARS_NZ  = 3'd6
   } cond_type;

   typedef struct packed {
      op_type                op;
      cond_type              cond;
      logic [StepWidth-1:0]  target;
   } ctrl_type;

   typedef struct packed {
      logic req_valid;
      logic out_free;
      logic is_hex;
      logic no_prefix;
      logic iter_nz;
      logic chars_nz;
   } status_type;

   localparam logic [StepWidth-1:0] StepIdle   = 4'd0;
   localparam logic [StepWidth-1:0] StepDabble = 4'd2;
   localparam logic [StepWidth-1:0] StepHex    = 4'd4;
   localparam logic [StepWidth-1:0] StepDigit  = 4'd7;

   function automatic ctrl_type ucode(input logic [StepWidth-1:0] addr);
      ctrl_type w;
      w = '{op: OP_NONE, cond: COND_ALWAYS, target: StepIdle};
      unique case (addr)
         4'd0: w = '{op: OP_LOAD,   cond: COND_NO_REQ,    target: StepIdle};
         4'd1: w = '{op: OP_NONE,   cond: COND_IS_HEX,    target: StepHex};
         4'd2: w = '{op: OP_DABBLE, cond: COND_ITER_NZ,   target: StepDabble};
         4'd3: w = '{op: OP_NONE,   cond: COND_ALWAYS,    target: StepDigit};
         4'd4: w = '{op: OP_NONE,   cond: COND_NO_PREFIX, target: StepDigit};
         4'd5: w = '{op: OP_EMIT_0, cond: COND_NEVER,     target: StepIdle};
         4'd6: w = '{op: OP_EMIT_X, cond: COND_NEVER,     target: StepIdle};
         4'd7: w = '{op: OP_EMIT_D, cond: COND_CHARS_NZ,  target: StepDigit};
         default: w = '{op: OP_NONE, cond: COND_ALWAYS,   target: StepIdle};
      endcase
      return w;
   endfunction

   function automatic logic [7:0] digit_char(input logic hex, input logic [3:0] nib);
      logic [7:0] c;
      if (hex && nib > 4'd9) begin
         c = CharHexOff + {4'd0, nib};
      end else begin
         c = CharZero + {4'd0, nib};
      end
      return c;
   endfunction

endpackage

/* src/ntoa_seq.sv */
// ----------------------------------------------------------------------------
// ntoa_seq
// Step counter and control store. Each step reads one control word; a
// conditional jump picks the next step, and emit steps hold while the
// output register is full.
// ----------------------------------------------------------------------------
module ntoa_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  ntoa_pkg::status_type status,
   output ntoa_pkg::ctrl_type   ctrl
);
   import ntoa_pkg::*;

   logic [StepWidth-1:0] step_ff;
   logic [StepWidth-1:0] step_in;
   logic                 taken;
   logic                 hold;

   assign ctrl = ucode(step_ff);

   always_comb begin
      unique case (ctrl.cond)
         COND_NEVER:     taken = 1'b0;
         COND_ALWAYS:    taken = 1'b1;
         COND_NO_REQ:    taken = !status.req_valid;
         COND_IS_HEX:    taken = status.is_hex;
         COND_NO_PREFIX: taken = status.no_prefix;
         COND_ITER_NZ:   taken = status.iter_nz;
         COND_CHARS_NZ:  taken = status.chars_nz;
         default:        taken = 1'b1;
      endcase
   end

   assign hold = (ctrl.op == OP_EMIT_0 || ctrl.op == OP_EMIT_X || ctrl.op == OP_EMIT_D)
                 && !status.out_free;

   always_comb begin
      if (hold) begin
         step_in = step_ff;
      end else if (taken) begin
         step_in = ctrl.target;
      end else begin
         step_in = step_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= StepIdle;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

/* src/ntoa_dp.sv */
// ----------------------------------------------------------------------------
// ntoa_dp
// Datapath: value and BCD registers with a shift-and-add-3 step, the
// character counter and the output register.
// ----------------------------------------------------------------------------
module ntoa_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  ntoa_pkg::ctrl_type   ctrl,
   output ntoa_pkg::status_type status,
   input  logic                 req_valid,
   input  logic [2:0]           req_cmd,
   input  logic [31:0]          req_value,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_char_code,
   output logic                 rsp_last
);
   import ntoa_pkg::*;

   logic [ValueWidth-1:0]  val_ff, val_in;
   logic [4*BcdDigits-1:0] bcd_ff, bcd_in, bcd_adj;
   logic [4:0]             iter_ff, iter_in;
   logic [3:0]             chars_ff, chars_in;
   logic                   hex_ff, hex_in;
   logic                   prefix_ff, prefix_in;
   logic                   valid_ff, valid_in;
   logic [7:0]             char_ff, char_in;
   logic                   last_ff, last_in;
   logic                   load;
   logic                   out_free;
   logic                   emit;
   logic [3:0]             nib;
   cmd_type                cmd;

   assign cmd      = cmd_type'(req_cmd);
   assign load     = (ctrl.op == OP_LOAD) && req_valid;
   assign out_free = !valid_ff || rsp_ready;
   assign emit     = (ctrl.op == OP_EMIT_0 || ctrl.op == OP_EMIT_X || ctrl.op == OP_EMIT_D)
                     && out_free;

   assign status.req_valid = req_valid;
   assign status.out_free  = out_free;
   assign status.is_hex    = hex_ff;
   assign status.no_prefix = !prefix_ff;
   assign status.iter_nz   = (iter_ff != 5'd0);
   assign status.chars_nz  = (chars_ff != 4'd0);

   always_comb begin
      for (int i = 0; i < BcdDigits; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   always_comb begin
      if (hex_ff) begin
         nib = val_ff[4*chars_ff[2:0] +: 4] & NibMask;
      end else begin
         nib = bcd_ff[4*chars_ff +: 4];
      end
   end

   always_comb begin
      val_in    = val_ff;
      bcd_in    = bcd_ff;
      iter_in   = iter_ff;
      chars_in  = chars_ff;
      hex_in    = hex_ff;
      prefix_in = prefix_ff;
      if (load) begin
         bcd_in  = '0;
         iter_in = 5'd31;
         unique case (cmd)
            CMD_DEC2: begin
               val_in = {24'd0, req_value[7:0]}; chars_in = 4'd1;
               hex_in = 1'b0; prefix_in = 1'b0;
            end
            CMD_DEC3: begin
               val_in = {24'd0, req_value[7:0]}; chars_in = 4'd2;
               hex_in = 1'b0; prefix_in = 1'b0;
            end
            CMD_DEC5: begin
               val_in = {16'd0, req_value[15:0]}; chars_in = 4'd4;
               hex_in = 1'b0; prefix_in = 1'b0;
            end
            CMD_DEC10: begin
               val_in = req_value; chars_in = 4'd9;
               hex_in = 1'b0; prefix_in = 1'b0;
            end
            CMD_HEX2_RAW: begin
               val_in = {24'd0, req_value[7:0]}; chars_in = 4'd1;
               hex_in = 1'b1; prefix_in = 1'b0;
            end
            CMD_HEX2: begin
               val_in = {24'd0, req_value[7:0]}; chars_in = 4'd1;
               hex_in = 1'b1; prefix_in = 1'b1;
            end
            CMD_HEX4: begin
               val_in = {16'd0, req_value[15:0]}; chars_in = 4'd3;
               hex_in = 1'b1; prefix_in = 1'b1;
            end
            CMD_HEX8: begin
               val_in = req_value; chars_in = 4'd7;
               hex_in = 1'b1; prefix_in = 1'b1;
            end
            default: begin
               val_in = req_value; chars_in = 4'd7;
               hex_in = 1'b1; prefix_in = 1'b1;
            end
         endcase
      end else if (ctrl.op == OP_DABBLE) begin
         bcd_in  = {bcd_adj[4*BcdDigits-2:0], val_ff[ValueWidth-1]};
         val_in  = {val_ff[ValueWidth-2:0], 1'b0};
         iter_in = iter_ff - 5'd1;
      end else if (emit && ctrl.op == OP_EMIT_D && chars_ff != 4'd0) begin
         chars_in = chars_ff - 4'd1;
      end
   end

   always_comb begin
      valid_in = valid_ff && !rsp_ready;
      char_in  = char_ff;
      last_in  = last_ff;
      if (emit) begin
         valid_in = 1'b1;
         last_in  = 1'b0;
         unique case (ctrl.op)
            OP_EMIT_0: char_in = CharZero;
            OP_EMIT_X: char_in = CharX;
            default: begin
               char_in = digit_char(hex_ff, nib);
               last_in = (chars_ff == 4'd0);
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff    <= val_in;
      bcd_ff    <= bcd_in;
      iter_ff   <= iter_in;
      chars_ff  <= chars_in;
      hex_ff    <= hex_in;
      prefix_ff <= prefix_in;
      char_ff   <= char_in;
      last_ff   <= last_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_char_code = char_ff;
   assign rsp_last      = last_ff;

endmodule

/* src/number_to_ascii_formatter.sv */
// ----------------------------------------------------------------------------
// number_to_ascii_formatter
// Prints one unsigned number as fixed-width decimal or hex ASCII text,
// one character per output transfer, most significant first.
//
//   Channel  Ports                            Direction
//   req      req_valid/ready, cmd, value      in
//   rsp      rsp_valid/ready, char_code, last out
//
// Decimal items run the 32-step shift-and-add-3 loop before their
// characters are sent; hex items skip it and go on to the optional 0x
// prefix and the digits. One item is worked at a time.
// Reset is synchronous and empties the output register and control store
// pointer. A stalled output holds the emit step until the transfer.
// ----------------------------------------------------------------------------
module number_to_ascii_formatter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_cmd,
   input  logic [31:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_char_code,
   output logic        rsp_last
);
   import ntoa_pkg::*;

   ctrl_type   ctrl;
   status_type status;

   assign req_ready = (ctrl.op == OP_LOAD);

   ntoa_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   ntoa_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl),
      .status        (status),
      .req_valid     (req_valid),
      .req_cmd       (req_cmd),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_char_code (rsp_char_code),
      .rsp_last      (rsp_last)
   );

endmodule
